// File: design/cfq_pkg.sv
// types, constants and helpers shared by the can frame queue text unit
// no dependencies
package cfq_pkg;

    // input word: one frame offer or one drain request
    typedef struct packed {
        logic        mode;
        logic        fd_frame;
        logic        rate_switch;
        logic        extended_id;
        logic [28:0] frame_id;
        logic [3:0]  byte_count;
        logic [63:0] payload;
    } t_in_word;

    // output word: one character of a text line
    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
    } t_out_word;

    // stored frame, also the drain job handed to the formatter
    typedef struct packed {
        logic        fd_frame;
        logic        rate_switch;
        logic        extended_id;
        logic [28:0] frame_id;
        logic [3:0]  byte_count;
        logic [63:0] payload;
    } t_frame;

    // job queue status seen by the front and the formatter
    typedef struct packed {
        logic       valid;
        logic [1:0] count;
    } t_jq_status;

    // input modes
    localparam logic MODE_OFFER = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    // job queue size
    localparam logic [1:0] JQ_FULL_CNT = 2'd2;

    // formatter sequencer states
    typedef enum logic [2:0] {
        FMT_IDLE,
        FMT_HEAD,
        FMT_ID,
        FMT_TAIL,
        FMT_DATA,
        FMT_CR,
        FMT_LF
    } t_fmt_state;

    // ascii characters used in a line
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_LBRK  = 8'h5b;
    localparam logic [7:0] CH_RBRK  = 8'h5d;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A_LC  = 8'h61;

    // lowercase hex digit
    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = CH_ZERO + {4'b0, nib};
        end else begin
            r = CH_A_LC + {4'b0, nib} - 8'd10;
        end
        return r;
    endfunction

endpackage

// File: design/cfq_front.sv
// front part: accepts words, keeps the frame ring and issues drain jobs
// depends on cfq_pkg
module cfq_front #(
    parameter int QUEUE_DEPTH    = 32,
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  cfq_pkg::t_in_word  i_in_word,
    input  cfq_pkg::t_jq_status i_jq_status,
    output logic               o_job_push,
    output cfq_pkg::t_frame    o_job
);
    import cfq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [3:0] MAX_CNT = 4'(MAX_DATA_BYTES);

    t_frame           r_mem [QUEUE_DEPTH];
    t_frame           r_rd_data;
    logic             r_rd_valid;
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic             r_full;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic             w_accept;
    logic             w_empty;
    logic             w_store;
    logic             w_take;
    t_frame           w_frame;

    // hold off input while the job queue could not take another drain
    assign full = (i_jq_status.count == JQ_FULL_CNT) ||
                  ((i_jq_status.count == 2'd1) && r_rd_valid);

    assign w_accept = push && !full;
    assign w_empty  = (r_wr_ptr == r_rd_ptr) && !r_full;
    assign w_store  = w_accept && (i_in_word.mode == MODE_OFFER) && !r_full;
    assign w_take   = w_accept && (i_in_word.mode == MODE_DRAIN) && !w_empty;

    assign n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;

    always_comb begin
        w_frame.fd_frame    = i_in_word.fd_frame;
        w_frame.rate_switch = i_in_word.rate_switch;
        w_frame.extended_id = i_in_word.extended_id;
        w_frame.frame_id    = i_in_word.frame_id;
        w_frame.byte_count  = i_in_word.byte_count;
        w_frame.payload     = i_in_word.payload;
    end

    // frame ring memory with registered read
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_wr_ptr] <= w_frame;
        end
        if (w_take) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    // ring pointers and pending read flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_full     <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= w_take;
            if (w_store) begin
                r_wr_ptr <= n_wr_ptr;
                r_full   <= (n_wr_ptr == r_rd_ptr);
            end
            if (w_take) begin
                r_rd_ptr <= n_rd_ptr;
                r_full   <= 1'b0;
            end
        end
    end

    // job out, byte count saturated
    always_comb begin
        o_job = r_rd_data;
        if (r_rd_data.byte_count > MAX_CNT) begin
            o_job.byte_count = MAX_CNT;
        end
    end
    assign o_job_push = r_rd_valid;

    ap_full_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_wr_ptr == r_rd_ptr))
        else $error("ring full flag without equal pointers");

    ap_job_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> (i_jq_status.count != JQ_FULL_CNT))
        else $error("drain job issued into a full job queue");

endmodule

// File: design/cfq_job_fifo.sv
// two-entry job queue between the front and the formatter
// depends on cfq_pkg
module cfq_job_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cfq_pkg::t_frame     i_job,
    input  logic                i_pop,
    output cfq_pkg::t_jq_status o_status,
    output cfq_pkg::t_frame     o_job
);
    import cfq_pkg::*;

    t_frame     r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign w_pop = i_pop && (r_count != 2'd0);

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            unique case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_status.valid = (r_count != 2'd0);
    assign o_status.count = r_count;
    assign o_job          = r_mem[r_rptr];

    ap_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == JQ_FULL_CNT) |-> !i_push)
        else $error("job queue overflow");

endmodule

// File: design/cfq_fmt.sv
// back part: turns one drain job into a text line, one character a cycle while pop keeps up
// depends on cfq_pkg
module cfq_fmt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cfq_pkg::t_jq_status i_jq_status,
    input  cfq_pkg::t_frame     i_job,
    output logic                o_job_pop,
    output logic                empty,
    input  logic                pop,
    output cfq_pkg::t_out_word  o_out_word
);
    import cfq_pkg::*;

    t_fmt_state      r_state;
    t_fmt_state      n_state;
    logic [2:0]      r_step;
    logic [2:0]      n_step;
    logic [2:0]      r_byte;
    logic [2:0]      n_byte;
    t_frame          r_job;
    t_out_word       r_out;
    logic            r_out_valid;
    logic            w_adv;
    logic            w_emit;
    t_out_word       w_char;
    logic [3:0][7:0] w_id_bytes;
    logic [7:0][7:0] w_data_bytes;
    logic [7:0]      w_hex_byte;

    // output register frees when empty or taken
    assign w_adv = !r_out_valid || pop;

    assign w_id_bytes   = {3'b000, r_job.frame_id};
    assign w_data_bytes = r_job.payload;

    // state register and line position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FMT_IDLE;
            r_step  <= 3'd0;
            r_byte  <= 3'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_byte  <= n_byte;
        end
    end

    // job capture
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
    end

    // character sequencer
    always_comb begin
        n_state          = r_state;
        n_step           = r_step;
        n_byte           = r_byte;
        w_emit           = 1'b0;
        w_char.text_char = CH_SPACE;
        w_char.last_char = 1'b0;
        o_job_pop        = 1'b0;
        w_hex_byte       = (r_state == FMT_ID) ? w_id_bytes[r_byte[1:0]]
                                               : w_data_bytes[r_byte];
        unique case (r_state)
            FMT_IDLE: begin
                if (i_jq_status.valid) begin
                    o_job_pop = 1'b1;
                    n_state   = FMT_HEAD;
                    n_step    = 3'd0;
                end
            end
            FMT_HEAD: begin
                w_emit = w_adv;
                unique case (r_step)
                    3'd0:    w_char.text_char = r_job.fd_frame ? CH_F : CH_C;
                    3'd1:    w_char.text_char = r_job.rate_switch ? CH_B : CH_DASH;
                    3'd2:    w_char.text_char = CH_SPACE;
                    3'd3:    w_char.text_char = r_job.extended_id ? CH_E : CH_S;
                    3'd4:    w_char.text_char = r_job.extended_id ? CH_X : CH_T;
                    3'd5:    w_char.text_char = r_job.extended_id ? CH_T : CH_D;
                    default: w_char.text_char = CH_LBRK;
                endcase
                if (w_adv) begin
                    if (r_step == 3'd6) begin
                        n_state = FMT_ID;
                        n_step  = 3'd0;
                        n_byte  = r_job.extended_id ? 3'd3 : 3'd1;
                    end else begin
                        n_step = r_step + 3'd1;
                    end
                end
            end
            FMT_ID, FMT_DATA: begin
                w_emit = w_adv;
                unique case (r_step)
                    3'd1:    w_char.text_char = hex_ascii(w_hex_byte[7:4]);
                    3'd2:    w_char.text_char = hex_ascii(w_hex_byte[3:0]);
                    default: w_char.text_char = CH_SPACE;
                endcase
                if (w_adv) begin
                    if (r_step == 3'd2) begin
                        n_step = 3'd0;
                        if (r_state == FMT_ID) begin
                            if (r_byte == 3'd0) begin
                                n_state = FMT_TAIL;
                            end else begin
                                n_byte = r_byte - 3'd1;
                            end
                        end else begin
                            if ({1'b0, r_byte} == r_job.byte_count - 4'd1) begin
                                n_state = FMT_CR;
                            end else begin
                                n_byte = r_byte + 3'd1;
                            end
                        end
                    end else begin
                        n_step = r_step + 3'd1;
                    end
                end
            end
            FMT_TAIL: begin
                w_emit = w_adv;
                unique case (r_step)
                    3'd1:    w_char.text_char = CH_RBRK;
                    3'd2:    w_char.text_char = CH_COLON;
                    default: w_char.text_char = CH_SPACE;
                endcase
                if (w_adv) begin
                    if (r_step == 3'd2) begin
                        n_step  = 3'd0;
                        n_byte  = 3'd0;
                        n_state = (r_job.byte_count == 4'd0) ? FMT_CR : FMT_DATA;
                    end else begin
                        n_step = r_step + 3'd1;
                    end
                end
            end
            FMT_CR: begin
                w_emit           = w_adv;
                w_char.text_char = CH_CR;
                if (w_adv) begin
                    n_state = FMT_LF;
                end
            end
            FMT_LF: begin
                w_emit           = w_adv;
                w_char.text_char = CH_LF;
                w_char.last_char = 1'b1;
                if (w_adv) begin
                    n_state = FMT_IDLE;
                end
            end
            default: begin
                n_state = FMT_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_char;
        end
    end

    assign empty      = !r_out_valid;
    assign o_out_word = r_out;

    ap_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FMT_DATA) |-> ((r_job.byte_count != 4'd0) &&
                                   (r_job.byte_count <= 4'd8)))
        else $error("data phase with bad byte count");

    ap_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> i_jq_status.valid)
        else $error("job taken from empty job queue");

endmodule

// File: design/can_frame_queue_to_hex_text_unit.sv
// top level of the can frame queue with hex text drain
// depends on cfq_pkg, cfq_front, cfq_job_fifo, cfq_fmt
//
// Offer words (mode 0) store a frame in a ring of QUEUE_DEPTH entries, or
// drop it when the ring is full; a drain word (mode 1) takes the oldest
// frame, if there is one, and yields one text line, one character per
// cycle while pop keeps up: 18 + 3 * bytes characters for a standard id,
// 24 + 3 * bytes for an extended id, 48 at most, the first one coming out
// after the ring memory read, the job queue and the formatter load.
// The formatter's single-character sequencer sets that rate. Up to two
// drain jobs wait between the ring and the formatter; full rises while
// that queue could not take another one. The ring memory needs no clearing
// after reset.
module can_frame_queue_to_hex_text_unit #(
    parameter int QUEUE_DEPTH    = 32,
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  cfq_pkg::t_in_word  i_in_word,
    output logic               empty,
    input  logic               pop,
    output cfq_pkg::t_out_word o_out_word
);
    import cfq_pkg::*;

    t_jq_status w_jq_status;
    logic       w_job_push;
    logic       w_job_pop;
    t_frame     w_job_in;
    t_frame     w_job_out;

    // ring and drain issue
    cfq_front #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_word   (i_in_word),
        .i_jq_status (w_jq_status),
        .o_job_push  (w_job_push),
        .o_job       (w_job_in)
    );

    // job queue
    cfq_job_fifo u_job_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_job_push),
        .i_job    (w_job_in),
        .i_pop    (w_job_pop),
        .o_status (w_jq_status),
        .o_job    (w_job_out)
    );

    // text formatter
    cfq_fmt u_fmt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_jq_status (w_jq_status),
        .i_job       (w_job_out),
        .o_job_pop   (w_job_pop),
        .empty       (empty),
        .pop         (pop),
        .o_out_word  (o_out_word)
    );

endmodule
